FILE: hdl/fpa_pkg.sv
// Shared types and codes for the fit-policy piece allocator.
package fpa_pkg;

  typedef struct packed {
    logic        func;
    logic [15:0] amount;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [15:0] remaining;
  } out_beat_t;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  localparam logic [1:0] ST_LOADED    = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_ALLOCATED = 2'd2;
  localparam logic [1:0] ST_NO_FIT    = 2'd3;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;
  localparam logic [1:0] POL_UNDEF = 2'd3;

endpackage

FILE: hdl/fpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/fit_policy_piece_allocator.sv
// Top level of the fit-policy piece allocator: sequencer, scan compare and output register.
//
// A load goes from acceptance straight to the result state. A request
// scans the table newest to oldest, one piece per cycle through the single
// read port of the piece RAM (read setup, one compare per piece, cut,
// result); first fit stops at the first piece that fits. A request on an
// empty table or with policy 3 goes straight to the result without a scan.
// One beat is in work at a time; the result waits in an output register.
module fit_policy_piece_allocator #(
  parameter int PIECES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  fpa_pkg::in_beat_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output fpa_pkg::out_beat_t out_data
);
  import fpa_pkg::*;

  localparam int AW = (PIECES > 1) ? $clog2(PIECES) : 1;
  localparam int CW = $clog2(PIECES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_CUT  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    policy_r, policy_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] scan_r, scan_nxt;
  logic [AW-1:0] pick_r, pick_nxt;
  logic [15:0]   pick_len_r, pick_len_nxt;
  logic          found_r, found_nxt;
  logic [15:0]   amount_r, amount_nxt;
  out_beat_t     res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_beat_t     out_data_r, out_data_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0]   wr_data, rd_data;
  logic          accept, full, fits, better;
  logic [16:0]   diff;
  logic [15:0]   cut_len;

  fpa_ram #(.WIDTH(16), .DEPTH(PIECES)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept  = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign full    = (count_r == CW'(PIECES));
  assign diff    = {1'b0, rd_data} - {1'b0, amount_r};
  assign fits    = !diff[16];
  assign cut_len = pick_len_r - amount_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    unique case (policy_r)
      POL_FIRST: better = fits;
      POL_BEST:  better = fits && (!found_r || rd_data < pick_len_r);
      POL_WORST: better = !found_r || rd_data > pick_len_r;
      default:   better = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    policy_nxt    = policy_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    pick_nxt      = pick_r;
    pick_len_nxt  = pick_len_r;
    found_nxt     = found_r;
    amount_nxt    = amount_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = pick_r;
    wr_data       = cut_len;
    rd_addr       = scan_r - AW'(1);

    if (cfg_wr_en) begin
      policy_nxt = cfg_wr_data;
    end
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        rd_addr = AW'(count_r - CW'(1));
        if (accept) begin
          amount_nxt = in_data.amount;
          found_nxt  = 1'b0;
          scan_nxt   = AW'(count_r - CW'(1));
          state_nxt  = S_DONE;
          if (in_data.func == FUNC_LOAD) begin
            if (full) begin
              res_nxt = '{status: ST_FULL, slot: 6'd0, remaining: 16'd0};
            end else begin
              wr_en     = 1'b1;
              wr_addr   = AW'(count_r);
              wr_data   = in_data.amount;
              count_nxt = count_r + CW'(1);
              res_nxt   = '{status: ST_LOADED, slot: 6'(count_r), remaining: 16'd0};
            end
          end else if (count_r == '0 || policy_r == POL_UNDEF) begin
            res_nxt = '{status: ST_NO_FIT, slot: 6'd0, remaining: 16'd0};
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        scan_nxt = scan_r - AW'(1);
        if (better) begin
          found_nxt    = 1'b1;
          pick_nxt     = scan_r;
          pick_len_nxt = rd_data;
        end
        if (scan_r == '0 || (policy_r == POL_FIRST && fits)) begin
          state_nxt = S_CUT;
        end
      end
      S_CUT: begin
        state_nxt = S_DONE;
        if (found_r && (policy_r != POL_WORST || amount_r < pick_len_r)) begin
          wr_en   = 1'b1;
          res_nxt = '{status: ST_ALLOCATED, slot: 6'(pick_r), remaining: cut_len};
        end else begin
          res_nxt = '{status: ST_NO_FIT, slot: 6'd0, remaining: 16'd0};
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= POL_FIRST;
      count_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      policy_r    <= policy_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r     <= scan_nxt;
    pick_r     <= pick_nxt;
    pick_len_r <= pick_len_nxt;
    amount_r   <= amount_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
